// File: hw/rtl/lrd_pkg.sv
// lrd_pkg: shared types and constants of the LZSS/RLE block decoder.
// No dependencies; imported by every module of the decoder except lrd_ram.
package lrd_pkg;

  localparam int BYTE_W      = 8;
  localparam int OFFSET_W    = 12;
  localparam int COUNT_W     = 13;
  localparam int FLAG_W      = 16;
  localparam int LEFT_W      = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam int RAW_GROUP   = 16;   // literals after a zero flag word
  localparam int COPY_BIAS   = 3;    // copy length = len + 3
  localparam int RUN_BIAS    = 16;   // run count = 12-bit field + 16

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_RUN,
    CMD_TRUNC
  } cmd_kind_t;

  // One decoded command passed from the parser to the executor.
  typedef struct packed {
    cmd_kind_t           kind;
    logic [BYTE_W-1:0]   data;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
  } cmd_t;

endpackage

// File: hw/rtl/lrd_ram.sv
// lrd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/lrd_front.sv
// lrd_front: flag-word/token parser; turns compressed bytes into commands.
// Depends on lrd_pkg.
module lrd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  logic                 block_end,
  input  logic                 q_full,
  output logic                 cmd_push,
  output lrd_pkg::cmd_t        cmd
);
  import lrd_pkg::*;

  typedef enum logic [2:0] {
    PH_FLAG_HI,
    PH_FLAG_LO,
    PH_RAW,
    PH_BITS,
    PH_TOK1,
    PH_TOK2,
    PH_TOK3
  } phase_t;

  phase_t              phase, phase_next;
  logic [FLAG_W-1:0]   flag_bits, flag_bits_next;
  logic [LEFT_W-1:0]   flag_left, flag_left_next;
  logic [LEFT_W-1:0]   lit_left, lit_left_next;
  logic [BYTE_W-1:0]   tok0, tok0_next;
  logic [BYTE_W-1:0]   tok1, tok1_next;
  logic [BYTE_W-1:0]   tok2, tok2_next;

  logic                accept;
  logic [LEFT_W-1:0]   flag_left_dec;
  logic [LEFT_W-1:0]   lit_left_dec;
  phase_t              phase_after_bit;
  logic [OFFSET_W-1:0] tok_offset;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // consuming one flag bit
  assign flag_left_dec   = flag_left - LEFT_W'(flag_left != '0);
  assign phase_after_bit = (flag_left_dec == '0) ? PH_FLAG_HI : PH_BITS;
  assign lit_left_dec    = lit_left - LEFT_W'(lit_left != '0);
  assign tok_offset      = {tok0, in_byte[7:4]};

  always_comb begin
    phase_next     = phase;
    flag_bits_next = flag_bits;
    flag_left_next = flag_left;
    lit_left_next  = lit_left;
    tok0_next      = tok0;
    tok1_next      = tok1;
    tok2_next      = tok2;
    cmd_push       = 1'b0;
    cmd.kind       = CMD_LIT;
    cmd.data       = in_byte;
    cmd.offset     = tok_offset;
    cmd.count      = COUNT_W'(1);

    if (accept) begin
      unique case (phase)
        PH_FLAG_HI: begin
          tok0_next  = in_byte;
          phase_next = PH_FLAG_LO;
        end
        PH_FLAG_LO: begin
          tok0_next = '0;
          if ({tok0, in_byte} == '0) begin
            lit_left_next = LEFT_W'(RAW_GROUP);
            phase_next    = PH_RAW;
          end else begin
            flag_bits_next = {tok0, in_byte};
            flag_left_next = LEFT_W'(FLAG_W);
            phase_next     = PH_BITS;
          end
        end
        PH_RAW: begin
          cmd_push      = 1'b1;
          lit_left_next = lit_left_dec;
          if (lit_left_dec == '0) begin
            phase_next = PH_FLAG_HI;
          end
        end
        PH_BITS: begin
          if (!flag_bits[FLAG_W-1]) begin
            cmd_push       = 1'b1;
            flag_bits_next = {flag_bits[FLAG_W-2:0], 1'b0};
            flag_left_next = flag_left_dec;
            phase_next     = phase_after_bit;
          end else begin
            tok0_next  = in_byte;
            phase_next = PH_TOK1;
          end
        end
        PH_TOK1: begin
          tok1_next = in_byte;
          if (tok_offset != '0) begin
            cmd_push       = 1'b1;
            cmd.kind       = CMD_COPY;
            cmd.count      = COUNT_W'(in_byte[3:0]) + COUNT_W'(COPY_BIAS);
            flag_bits_next = {flag_bits[FLAG_W-2:0], 1'b0};
            flag_left_next = flag_left_dec;
            phase_next     = phase_after_bit;
          end else begin
            phase_next = PH_TOK2;
          end
        end
        PH_TOK2: begin
          tok2_next  = in_byte;
          phase_next = PH_TOK3;
        end
        PH_TOK3: begin
          cmd_push       = 1'b1;
          cmd.kind       = CMD_RUN;
          cmd.count      = COUNT_W'({tok1[3:0], tok2}) + COUNT_W'(RUN_BIAS);
          flag_bits_next = {flag_bits[FLAG_W-2:0], 1'b0};
          flag_left_next = flag_left_dec;
          phase_next     = phase_after_bit;
        end
        default: begin
          phase_next     = PH_FLAG_HI;
          flag_left_next = '0;
          lit_left_next  = '0;
        end
      endcase

      if (block_end) begin
        // cut-off flag word or token: drop it and report a marker
        if (phase_next == PH_FLAG_LO || phase_next == PH_TOK1 ||
            phase_next == PH_TOK2 || phase_next == PH_TOK3) begin
          cmd_push  = 1'b1;
          cmd.kind  = CMD_TRUNC;
          cmd.data  = '0;
          cmd.count = '0;
        end
        phase_next     = PH_FLAG_HI;
        flag_left_next = '0;
        lit_left_next  = '0;
        tok0_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FLAG_HI;
      flag_left <= '0;
      lit_left  <= '0;
      flag_bits <= '0;
      tok0      <= '0;
    end else begin
      phase     <= phase_next;
      flag_left <= flag_left_next;
      lit_left  <= lit_left_next;
      flag_bits <= flag_bits_next;
      tok0      <= tok0_next;
    end
    tok1 <= tok1_next;
    tok2 <= tok2_next;
  end

endmodule

// File: hw/rtl/lrd_cmd_queue.sv
// lrd_cmd_queue: short register FIFO of commands between parser and executor.
// Depends on lrd_pkg.
module lrd_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lrd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output lrd_pkg::cmd_t head_cmd
);
  import lrd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign full       = (fill == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

// File: hw/rtl/lrd_back.sv
// lrd_back: command executor; history RAM, copy/run sequencing, output register.
// Depends on lrd_pkg and lrd_ram.
module lrd_back #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  lrd_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic [12:0]   run_count,
  output logic          truncated,
  output logic          last
);
  import lrd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(HISTORY_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD,
    ST_WR
  } state_t;

  state_t              state;
  logic [AW-1:0]       ptr, ptr_inc;
  logic [COUNT_W-1:0]  remaining;
  logic [OFFSET_W-1:0] offset;
  logic [BYTE_W-1:0]   fill_byte;

  logic                out_free;
  logic [AW:0]         diff, diff_wrap;
  logic [AW-1:0]       src;
  logic                wr_en, rd_en;
  logic [BYTE_W-1:0]   wr_data, rd_data;

  assign out_free = !out_valid || !out_stall;
  assign ptr_inc  = (ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr + 1'b1;

  // source = (ptr - offset) mod depth
  assign diff      = {1'b0, ptr} - (AW+1)'(offset);
  assign diff_wrap = diff + DEPTH_W;
  assign src       = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];

  assign q_pop = (state == ST_IDLE) && q_valid &&
                 (out_free || q_cmd.kind == CMD_COPY);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = rd_data;
    unique case (state)
      ST_IDLE: begin
        wr_en   = q_pop && (q_cmd.kind == CMD_LIT || q_cmd.kind == CMD_RUN);
        wr_data = q_cmd.data;
      end
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_data = fill_byte;
      end
      ST_RD: begin
        wr_en = 1'b0;
      end
      ST_WR: begin
        wr_en = out_free;
      end
    endcase
  end

  assign rd_en = (state == ST_RD);

  lrd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ptr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (src),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      ptr       <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            unique case (q_cmd.kind)
              CMD_LIT: begin
                out_valid <= 1'b1;
                out_byte  <= q_cmd.data;
                run_count <= COUNT_W'(1);
                truncated <= 1'b0;
                last      <= 1'b1;
                ptr       <= ptr_inc;
              end
              CMD_TRUNC: begin
                out_valid <= 1'b1;
                out_byte  <= '0;
                run_count <= '0;
                truncated <= 1'b1;
                last      <= 1'b1;
              end
              CMD_RUN: begin
                out_valid <= 1'b1;
                out_byte  <= q_cmd.data;
                run_count <= q_cmd.count;
                truncated <= 1'b0;
                last      <= 1'b1;
                ptr       <= ptr_inc;
                remaining <= q_cmd.count - 1'b1;
                fill_byte <= q_cmd.data;
                state     <= ST_FILL;
              end
              CMD_COPY: begin
                remaining <= q_cmd.count;
                offset    <= q_cmd.offset;
                state     <= ST_RD;
              end
            endcase
          end
        end
        ST_FILL: begin
          ptr       <= ptr_inc;
          remaining <= remaining - 1'b1;
          if (remaining == COUNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        ST_RD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= rd_data;
            run_count <= COUNT_W'(1);
            truncated <= 1'b0;
            last      <= (remaining == COUNT_W'(1));
            ptr       <= ptr_inc;
            remaining <= remaining - 1'b1;
            state     <= (remaining == COUNT_W'(1)) ? ST_IDLE : ST_RD;
          end
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/lzss_rle_block_decoder.sv
// lzss_rle_block_decoder: top level of the LZSS decoder with run tokens.
// Depends on lrd_pkg, lrd_front, lrd_cmd_queue, lrd_back (and lrd_ram).
//
// Usage:
//   Input channel (in_valid/in_stall, in_byte, block_end): one compressed
//   byte per transaction; block_end marks the last byte of a block and
//   returns the flag/token parse to its start. The history window persists.
//   Output channel (out_valid/out_stall, out_byte, run_count, truncated,
//   last): one decoded result per transaction. last flags the final result
//   caused by an input byte; a run token comes out as one result with
//   run_count 16..4111; a token cut off by block_end yields one marker with
//   truncated=1, out_byte=0, run_count=0.
//   Timing: the parser takes one byte per cycle while the two-entry command
//   queue has room. The executor takes a literal or marker straight from idle;
//   a copy starts from idle, then does a history read and a write-back per
//   copied byte; a run is written into the history one byte a cycle. It takes
//   a new command only when idle. A literal passes the queue entry and the
//   output register; the first byte of a copy also the history read.
//   Stalling: out_stall holds the output register; the executor waits, the
//   queue fills, and then in_stall rises. Nothing is dropped.
//   Reset (rst, synchronous): clears parse state, queue, history pointer and
//   output valid; history contents stay. Copies must read only written bytes; not enforced.
module lzss_rle_block_decoder #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        block_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [12:0] run_count,
  output logic        truncated,
  output logic        last
);
  import lrd_pkg::*;

  logic cmd_push;
  cmd_t cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  // front: byte parser
  lrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .block_end (block_end),
    .q_full    (q_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  // decouples the parser from the executor
  lrd_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  // back: history window, copy and run sequencing, output register
  lrd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_count (run_count),
    .truncated (truncated),
    .last      (last)
  );

endmodule

// File: test/lzss_rle_block_decoder_tb.sv
// Self-checking testbench for lzss_rle_block_decoder: directed and random
// compressed streams, predicted by a scoreboard class. Depends on lrd_pkg and lzss_rle_block_decoder.
`timescale 1ns / 1ps

module lzss_rle_block_decoder_tb;
  import lrd_pkg::*;

  localparam int HIST_DEPTH  = 4096;
  localparam int RANDOM_ITEMS = 180;
  localparam int QUIET_AFTER = 150;     // no idling past this many random bytes
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef enum logic [2:0] {
    PH_FLAG_HI,
    PH_FLAG_LO,
    PH_RAW,
    PH_BITS,
    PH_TOK1,
    PH_TOK2,
    PH_TOK3
  } parse_phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               trunc;
    logic               fin;
  } result_t;

  // Scoreboard: decodes each accepted byte into the results it must cause and
  // matches the output stream against them in order.
  class decoder_scoreboard;
    parse_phase_e       phase;
    logic [FLAG_W-1:0]  flags;
    int                 flags_left;
    int                 raw_left;
    logic [BYTE_W-1:0]  tok [3];
    logic [BYTE_W-1:0]  window [HIST_DEPTH];
    logic [OFFSET_W-1:0] wr_ptr;
    result_t            decoded_q [$];
    int                 errors;

    function void reset_state();
      clear_parse();
      foreach (window[i]) window[i] = '0;
      wr_ptr = '0;
      errors = 0;
      decoded_q.delete();
    endfunction

    function void clear_parse();
      phase = PH_FLAG_HI;
      flags = '0;
      flags_left = 0;
      raw_left = 0;
      foreach (tok[i]) tok[i] = '0;
    endfunction

    function void put_window(logic [BYTE_W-1:0] v);
      window[wr_ptr] = v;
      wr_ptr = wr_ptr + 1'b1;
    endfunction

    function void next_flag();
      flags = flags << 1;
      if (flags_left > 0) flags_left--;
      phase = (flags_left == 0) ? PH_FLAG_HI : PH_BITS;
    endfunction

    function result_t make_result(logic [BYTE_W-1:0] b, int cnt, logic tr);
      result_t r;
      r.data = b;
      r.count = COUNT_W'(cnt);
      r.trunc = tr;
      r.fin = 1'b0;
      return r;
    endfunction

    // Works out every result that one accepted byte causes.
    function void decode_byte(logic [BYTE_W-1:0] b, logic e);
      result_t batch [$];
      logic [FLAG_W-1:0] word;
      logic [OFFSET_W-1:0] off;
      logic [OFFSET_W-1:0] src;
      logic [BYTE_W-1:0] v;
      int len;
      int cnt;
      case (phase)
        PH_FLAG_HI: begin
          tok[0] = b;
          phase = PH_FLAG_LO;
        end
        PH_FLAG_LO: begin
          word = {tok[0], b};
          tok[0] = '0;
          if (word == '0) begin
            raw_left = RAW_GROUP;
            phase = PH_RAW;
          end else begin
            flags = word;
            flags_left = FLAG_W;
            phase = PH_BITS;
          end
        end
        PH_RAW: begin
          batch.push_back(make_result(b, 1, 1'b0));
          put_window(b);
          if (raw_left > 0) raw_left--;
          if (raw_left == 0) phase = PH_FLAG_HI;
        end
        PH_BITS: begin
          if (!flags[FLAG_W-1]) begin
            batch.push_back(make_result(b, 1, 1'b0));
            put_window(b);
            next_flag();
          end else begin
            tok[0] = b;
            phase = PH_TOK1;
          end
        end
        PH_TOK1: begin
          off = {tok[0], b[7:4]};
          tok[1] = b;
          if (off != '0) begin
            // byte by byte, so an overlapping copy repeats what it just wrote
            len = int'(b[3:0]) + COPY_BIAS;
            repeat (len) begin
              src = wr_ptr - off;
              v = window[src];
              batch.push_back(make_result(v, 1, 1'b0));
              put_window(v);
            end
            next_flag();
          end else begin
            phase = PH_TOK2;
          end
        end
        PH_TOK2: begin
          tok[2] = b;
          phase = PH_TOK3;
        end
        PH_TOK3: begin
          cnt = int'({tok[1][3:0], tok[2]}) + RUN_BIAS;
          batch.push_back(make_result(b, cnt, 1'b0));
          repeat (cnt) put_window(b);
          next_flag();
        end
      endcase
      if (e) begin
        if (phase == PH_FLAG_LO || phase == PH_TOK1 || phase == PH_TOK2 ||
            phase == PH_TOK3)
          batch.push_back(make_result('0, 0, 1'b1));
        clear_parse();
      end
      if (batch.size() > 0) batch[batch.size()-1].fin = 1'b1;
      foreach (batch[i]) decoded_q.push_back(batch[i]);
    endfunction

    function void check_result(logic [BYTE_W-1:0] b, logic [COUNT_W-1:0] cnt,
                               logic tr, logic lt);
      result_t want;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: expected no result, got byte %h count %0d trunc %b last %b",
                 $time, b, cnt, tr, lt);
        return;
      end
      want = decoded_q.pop_front();
      if (want.data !== b || want.count !== cnt || want.trunc !== tr ||
          want.fin !== lt) begin
        errors++;
        $display("%0t: byte/count/trunc/last expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                 $time, want.data, want.count, want.trunc, want.fin, b, cnt, tr, lt);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        block_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [12:0] run_count;
  logic        truncated;
  logic        last;

  decoder_scoreboard sb;
  bit quiet = 1'b0;
  int random_sent = 0;
  int stall_left = 0;
  int cycles = 0;

  lzss_rle_block_decoder #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .block_end(block_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .run_count(run_count),
    .truncated(truncated),
    .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output side: stall in random bursts, none started once quiet.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(out_byte, run_count, truncated, last);
  end

  // One input transaction; an idle burst may come before it. in_valid is
  // only lowered in a step where it is not raised again.
  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    block_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.decode_byte(b, e);
  endtask

  // Well-formed group with random content; the block may end at its last
  // byte or anywhere inside it, which cuts the flag word or a token.
  task automatic send_group();
    logic [7:0] grp [$];
    logic [15:0] word;
    logic [3:0] nib;
    int n;
    int cut;
    int off;
    int sel;
    word = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom_range(1, 16'hffff));
    grp.push_back(word[15:8]);
    grp.push_back(word[7:0]);
    if (word == 16'h0000) begin
      n = $urandom_range(1, RAW_GROUP);
      repeat (n) grp.push_back(8'($urandom));
      // a short raw group has to close its block or the parse stays in it
      cut = (n < RAW_GROUP || $urandom_range(0, 1) == 1) ? grp.size() - 1 : -1;
    end else begin
      for (int i = FLAG_W - 1; i >= 0; i--) begin
        if (!word[i]) begin
          grp.push_back(8'($urandom));
        end else if ($urandom_range(0, 9) < 7) begin
          off = $urandom_range(1, HIST_DEPTH - 1);
          nib = 4'($urandom);
          grp.push_back(8'(off >> 4));
          grp.push_back({off[3:0], nib});
        end else begin
          // runs mostly short: a long one keeps the executor busy filling the history
          nib = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h0;
          grp.push_back(8'h00);
          grp.push_back({4'h0, nib});
          grp.push_back(8'($urandom));
          grp.push_back(8'($urandom));
        end
      end
      sel = $urandom_range(0, 19);
      cut = (sel < 11) ? -1 : (sel < 16) ? grp.size() - 1 : $urandom_range(0, grp.size() - 1);
    end
    for (int i = 0; i < grp.size(); i++) begin
      send_byte(grp[i], i == cut);
      random_sent++;
      if (i == cut) break;
    end
  endtask

  // Raw random bytes, usually closed by a block end to realign the parse.
  task automatic send_noise();
    int n;
    logic e;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      e = (i == n - 1) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) == 0);
      send_byte(8'($urandom), e);
      random_sent++;
    end
  endtask

  // Directed stream, {block_end, byte}. The history is empty at the start, so
  // the first copy only reads back the literal just before it; the long run
  // then fills the whole window before anything random is sent.
  logic [8:0] directed_q [$] = '{
    // zero flag word, raw literals at both extremes, block cut short
    9'h000, 9'h000, 9'h000, 9'h1FF,
    // literal, overlapping 18-byte copy at offset 1, longest run, literal
    9'h060, 9'h000, 9'h0A5, 9'h000, 9'h01F, 9'h000, 9'h00F, 9'h0FF, 9'h0C3, 9'h111,
    // shortest copy at the farthest offset, block ends right after it
    9'h080, 9'h000, 9'h0FF, 9'h1F0,
    // shortest run, block ends on its fill byte
    9'h080, 9'h000, 9'h000, 9'h000, 9'h000, 9'h17E,
    // flag word alone ends the block: no result
    9'h012, 9'h134,
    // block ends in the flag word
    9'h1AB,
    // block ends after the first token byte
    9'h080, 9'h000, 9'h1FF,
    // block ends inside a run token
    9'h080, 9'h000, 9'h000, 9'h105
  };

  initial begin
    sb = new;
    sb.reset_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_q[i]) send_byte(directed_q[i][7:0], directed_q[i][8]);

    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_group();
      if (random_sent >= QUIET_AFTER) quiet = 1'b1;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
